### design/pema_pkg.sv
// Shared widths, event codes and payload types for the pen event moving-average filter.
package pema_pkg;

    localparam int VALUE_W = 32;
    localparam int TYPE_W  = 8;
    localparam int CODE_W  = 16;
    localparam int HALF_W  = 16;

    localparam logic [TYPE_W-1:0] ABS_AXIS_TYPE = 8'd3;
    localparam logic [CODE_W-1:0] CODE_X        = 16'd0;
    localparam logic [CODE_W-1:0] CODE_Y        = 16'd1;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [TYPE_W-1:0]  t_type;
    typedef logic [CODE_W-1:0]  t_code;

endpackage

### design/pema_ring.sv
// Per-axis sample ring with running total and prefetched oldest entry.
module pema_ring #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_push,
    input  pema_pkg::t_value                                     i_value,
    output logic [pema_pkg::VALUE_W+$clog2(WINDOW_DEPTH)-1:0]    o_total
);
    import pema_pkg::*;

    localparam int LW = $clog2(WINDOW_DEPTH);
    localparam int TW = VALUE_W + LW;
    localparam logic [LW-1:0] LAST      = LW'(WINDOW_DEPTH - 1);
    localparam logic [TW-1:0] TOTAL_MAX = TW'(WINDOW_DEPTH) * TW'({VALUE_W{1'b1}});

    t_value                  mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_valid;
    logic [LW-1:0]           r_pos;
    logic [LW-1:0]           p_push;
    logic [LW-1:0]           rd_addr;
    logic [TW-1:0]           r_total;
    logic [TW-1:0]           n_total;
    t_value                  r_rd_data;
    t_value                  old_value;
    logic                    r_rd_valid;

    // the read port always holds the entry that the next push replaces
    always_comb begin
        p_push = (r_pos == LAST) ? '0 : r_pos + LW'(1);
        if (i_push) begin
            rd_addr = (p_push == LAST) ? '0 : p_push + LW'(1);
        end else begin
            rd_addr = p_push;
        end
        old_value = r_rd_valid ? r_rd_data : '0;
        n_total   = r_total - TW'(old_value) + TW'(i_value);
    end

    assign o_total = n_total;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[p_push] <= i_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_total    <= '0;
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[rd_addr];
            if (i_push) begin
                r_pos           <= p_push;
                r_total         <= n_total;
                r_valid[p_push] <= 1'b1;
            end
        end
    end

    a_prefetch_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> r_valid[p_push])
        else $error("prefetched entry was never written");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TOTAL_MAX)
        else $error("running total exceeds window maximum");

    a_push_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |=> r_valid[r_pos])
        else $error("pushed entry not marked written");

endmodule

### design/pema_div.sv
// Four-stage divide of the running total by the window via reciprocal multiply.
module pema_div #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    output logic                                              o_stall,
    input  logic [pema_pkg::VALUE_W+$clog2(WINDOW_DEPTH)-1:0] i_total,
    input  pema_pkg::t_value                                  i_value,
    input  logic                                              i_averaged,
    output logic                                              o_valid,
    input  logic                                              i_stall,
    output pema_pkg::t_value                                  o_value,
    output logic                                              o_averaged
);
    import pema_pkg::*;

    localparam int LW = $clog2(WINDOW_DEPTH);
    localparam int TW = VALUE_W + LW;
    localparam int XW = HALF_W + LW;
    localparam int MW = XW + 2;
    localparam int PW = XW + MW;
    localparam int SH = XW + LW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
    localparam logic [XW-1:0] DEPTH_X = XW'(WINDOW_DEPTH);

    // total = hi * 2^16 + lo; hi / D first, then (rem * 2^16 + lo) / D
    logic                rdy_a, rdy_b, rdy_c, rdy_d;
    logic                r_va, r_vb, r_vc, r_vd;

    logic [PW-1:0]       r_pa;
    logic [XW-1:0]       r_a;
    logic [HALF_W-1:0]   r_lo_a;
    t_value              r_value_a;
    logic                r_avg_a;

    logic [HALF_W-1:0]   r_qa_b;
    logic [XW-1:0]       r_x2;
    t_value              r_value_b;
    logic                r_avg_b;

    logic [PW-1:0]       r_pb;
    logic [HALF_W-1:0]   r_qa_c;
    t_value              r_value_c;
    logic                r_avg_c;

    t_value              r_out;
    logic                r_avg_d;

    logic [XW-1:0]       hi_part;
    logic [HALF_W-1:0]   qa;
    logic [XW-1:0]       ra_full;
    logic [HALF_W-1:0]   qb;

    assign rdy_d   = !r_vd || !i_stall;
    assign rdy_c   = !r_vc || rdy_d;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_stall = !rdy_a;

    assign hi_part = i_total[TW-1:HALF_W];
    assign qa      = r_pa[SH +: HALF_W];
    assign ra_full = r_a - XW'(qa) * DEPTH_X;
    assign qb      = r_pb[SH +: HALF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
            if (rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_pa      <= PW'(hi_part) * PW'(RECIP);
            r_a       <= hi_part;
            r_lo_a    <= i_total[HALF_W-1:0];
            r_value_a <= i_value;
            r_avg_a   <= i_averaged;
        end
        if (rdy_b) begin
            r_qa_b    <= qa;
            r_x2      <= {ra_full[LW-1:0], r_lo_a};
            r_value_b <= r_value_a;
            r_avg_b   <= r_avg_a;
        end
        if (rdy_c) begin
            r_pb      <= PW'(r_x2) * PW'(RECIP);
            r_qa_c    <= r_qa_b;
            r_value_c <= r_value_b;
            r_avg_c   <= r_avg_b;
        end
        if (rdy_d) begin
            r_out   <= r_avg_c ? {r_qa_c, qb} : r_value_c;
            r_avg_d <= r_avg_c;
        end
    end

    assign o_valid    = r_vd;
    assign o_value    = r_out;
    assign o_averaged = r_avg_d;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va && r_avg_a |-> (ra_full < DEPTH_X))
        else $error("first partial remainder not below window");

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va && r_avg_a |-> (r_pa[PW-1:SH+HALF_W] == '0))
        else $error("upper partial quotient overflows");

    a_drain_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

endmodule

### design/pen_event_moving_average.sv
// Top level: pen event moving-average filter over x and y absolute axes.
//
//  Channel | Handshake          | Fields
//  --------+--------------------+------------------------------------------------
//  in      | i_valid / o_stall  | i_event_type, i_event_code, i_event_value
//  out     | o_valid / i_stall  | o_out_value, o_was_averaged
//
// One transfer in per cycle sustained while the output is not stalled.
// Stage 1 updates the axis ring (one read, one add, one subtract); four further stages
// divide the total by the window with two reciprocal multiplies.
// Synchronous reset clears ring positions, totals and entry valid bits; no clearing pass.
// An output stall backs up stage by stage; any empty stage still lets a transfer in.
module pen_event_moving_average #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  pema_pkg::t_type  i_event_type,
    input  pema_pkg::t_code  i_event_code,
    input  pema_pkg::t_value i_event_value,
    output logic             o_valid,
    input  logic             i_stall,
    output pema_pkg::t_value o_out_value,
    output logic             o_was_averaged
);
    import pema_pkg::*;

    localparam int LW = $clog2(WINDOW_DEPTH);
    localparam int TW = VALUE_W + LW;

    logic          r_v0;
    t_type         r_type0;
    t_code         r_code0;
    t_value        r_value0;

    logic          r_v1;
    logic [TW-1:0] r_total1;
    t_value        r_value1;
    logic          r_avg1;

    logic          rdy0, rdy1;
    logic          div_stall;
    logic          is_x, is_y;
    logic          push_x, push_y;
    logic [TW-1:0] x_total, y_total;

    assign is_x   = (r_type0 == ABS_AXIS_TYPE) && (r_code0 == CODE_X);
    assign is_y   = (r_type0 == ABS_AXIS_TYPE) && (r_code0 == CODE_Y);
    assign rdy1   = !r_v1 || !div_stall;
    assign rdy0   = !r_v0 || rdy1;
    assign push_x = r_v0 && rdy1 && is_x;
    assign push_y = r_v0 && rdy1 && is_y;
    assign o_stall = !rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_type0  <= i_event_type;
            r_code0  <= i_event_code;
            r_value0 <= i_event_value;
        end
        if (rdy1) begin
            r_total1 <= is_x ? x_total : y_total;
            r_value1 <= r_value0;
            r_avg1   <= is_x || is_y;
        end
    end

    pema_ring #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ring_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_x),
        .i_value (r_value0),
        .o_total (x_total)
    );

    pema_ring #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ring_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_y),
        .i_value (r_value0),
        .o_total (y_total)
    );

    pema_div #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v1),
        .o_stall    (div_stall),
        .i_total    (r_total1),
        .i_value    (r_value1),
        .i_averaged (r_avg1),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_out_value),
        .o_averaged (o_was_averaged)
    );

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v0)
        else $error("accepted transfer not held in input stage");

    a_stage0_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 && !rdy1 |=> r_v0 && $stable(r_value0) && $stable(r_code0))
        else $error("blocked input stage lost its item");

    a_empty_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v0 |-> !o_stall)
        else $error("empty input stage stalls the sender");

endmodule
